>>> src/double_ended_queue_assert.svh
// Assertion macros for the double-ended queue RTL.
// Used by dq_ctrl and double_ended_queue; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define DQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dq assertion failed");
// Next-cycle implication, checked outside reset.
`define DQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dq assertion failed");
`else
`define DQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define DQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> src/dq_pkg.sv
// Shared types, sizes and codes for the double-ended queue.
// No dependencies; used by dq_ctrl, double_ended_queue and the testbench, not by dq_ram.
package dq_pkg;

  localparam int DQ_DEPTH = 1024;
  localparam int DQ_AW    = $clog2(DQ_DEPTH);
  localparam int DQ_CW    = $clog2(DQ_DEPTH + 1);
  localparam int DQ_DW    = 32;

  // Command codes
  localparam logic [2:0] CMD_PUSH_FRONT   = 3'd0;
  localparam logic [2:0] CMD_PUSH_AT_BACK = 3'd1;
  localparam logic [2:0] CMD_POP_AT_FRONT = 3'd2;
  localparam logic [2:0] CMD_POP_BACK     = 3'd3;
  localparam logic [2:0] CMD_PEEK_FRONT   = 3'd4;
  localparam logic [2:0] CMD_PEEK_BACK    = 3'd5;
  localparam logic [2:0] CMD_CLEAR        = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Per-command decision from the pointer controller
  typedef struct packed {
    logic             wr_en;
    logic [DQ_AW-1:0] wr_addr;
    logic             rd_en;
    logic [DQ_AW-1:0] rd_addr;
    logic [1:0]       status;
    logic [DQ_CW-1:0] count;
  } dq_op_t;

endpackage

>>> src/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/dq_ctrl.sv
// Pointer and count controller: decodes a command, picks RAM addresses
// and updates front/back pointers and the element count. Uses dq_pkg.
`include "double_ended_queue_assert.svh"

module dq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [2:0]     cmd,
  output dq_pkg::dq_op_t op
);

  logic [dq_pkg::DQ_AW-1:0] front_r, front_nxt, back_r, back_nxt;
  logic [dq_pkg::DQ_AW-1:0] front_inc, front_dec, back_inc, back_dec;
  logic [dq_pkg::DQ_CW-1:0] count_r, count_nxt;
  logic                     is_push, is_read, full, empty;

  localparam logic [dq_pkg::DQ_AW-1:0] LastAddr = dq_pkg::DQ_AW'(dq_pkg::DQ_DEPTH - 1);
  localparam logic [dq_pkg::DQ_CW-1:0] FullCount = dq_pkg::DQ_CW'(dq_pkg::DQ_DEPTH);

  // Ring neighbors of both pointers
  assign front_inc = (front_r == LastAddr) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? LastAddr : front_r - 1'b1;
  assign back_inc  = (back_r == LastAddr) ? '0 : back_r + 1'b1;
  assign back_dec  = (back_r == '0) ? LastAddr : back_r - 1'b1;

  assign is_push = (cmd == dq_pkg::CMD_PUSH_FRONT) || (cmd == dq_pkg::CMD_PUSH_AT_BACK);
  assign is_read = (cmd == dq_pkg::CMD_POP_AT_FRONT) || (cmd == dq_pkg::CMD_POP_BACK) ||
                   (cmd == dq_pkg::CMD_PEEK_FRONT) || (cmd == dq_pkg::CMD_PEEK_BACK);
  assign full    = (count_r == FullCount);
  assign empty   = (count_r == '0);

  // Decode the command into RAM access and next pointer state
  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    op.wr_en   = 1'b0;
    op.wr_addr = '0;
    op.rd_en   = 1'b0;
    op.rd_addr = '0;
    op.status  = dq_pkg::ST_OK;
    if (is_push && full) begin
      op.status = dq_pkg::ST_FULL;
    end else if (is_read && empty) begin
      op.status = dq_pkg::ST_EMPTY;
    end else begin
      case (cmd)
        dq_pkg::CMD_PUSH_FRONT: begin
          op.wr_en   = 1'b1;
          op.wr_addr = front_r;
          front_nxt  = front_inc;
          count_nxt  = count_r + 1'b1;
        end
        dq_pkg::CMD_PUSH_AT_BACK: begin
          op.wr_en   = 1'b1;
          op.wr_addr = back_r;
          back_nxt   = back_dec;
          count_nxt  = count_r + 1'b1;
        end
        dq_pkg::CMD_POP_AT_FRONT: begin
          op.rd_en   = 1'b1;
          op.rd_addr = front_dec;
          front_nxt  = front_dec;
          count_nxt  = count_r - 1'b1;
        end
        dq_pkg::CMD_POP_BACK: begin
          op.rd_en   = 1'b1;
          op.rd_addr = back_inc;
          back_nxt   = back_inc;
          count_nxt  = count_r - 1'b1;
        end
        dq_pkg::CMD_PEEK_FRONT: begin
          op.rd_en   = 1'b1;
          op.rd_addr = front_dec;
        end
        dq_pkg::CMD_PEEK_BACK: begin
          op.rd_en   = 1'b1;
          op.rd_addr = back_inc;
        end
        dq_pkg::CMD_CLEAR: begin
          front_nxt = '0;
          back_nxt  = LastAddr;
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
    op.count = count_nxt;
  end

  // Advance pointers on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= LastAddr;
      count_r <= '0;
    end else if (accept) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  `DQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= FullCount)
  `DQ_ASSERT_NOW(a_one_port, clk, rst_n, 1'b1, !(op.wr_en && op.rd_en))
  `DQ_ASSERT_NXT(a_push_grows, clk, rst_n, accept && is_push && !full,
                 count_r == $past(count_r) + 1'b1)
  `DQ_ASSERT_NOW(a_empty_wrap, clk, rst_n, empty, front_inc == back_inc + 1'b1 ||
                 (front_r == '0 && back_r == LastAddr) || front_dec == back_r)

endmodule

>>> src/double_ended_queue.sv
// Double-ended queue of signed 32-bit words in a 1024-entry ring RAM.
// The RAM is read at the input transfer edge into the one-deep read stage, and the result
// then moves on into the output register once that register is free or being emptied.
// Throughput: one command per cycle while in_ready is high, set by the single RAM read/write port pair.
// A result waiting on the output does not block the next command until the
// one-deep read stage behind it is also full. Reset: synchronous active-low; queue empty.
`include "double_ended_queue_assert.svh"

module double_ended_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_cmd,
  input  logic signed [dq_pkg::DQ_DW-1:0]  in_push_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_status,
  output logic signed [dq_pkg::DQ_DW-1:0]  out_read_data,
  output logic [dq_pkg::DQ_CW-1:0]         out_element_count
);

  dq_pkg::dq_op_t           op;
  logic                     accept, pend_move;
  logic [dq_pkg::DQ_DW-1:0] ram_rdata;

  logic                     pend_r;
  logic                     pend_rd_r;
  logic [1:0]               pend_status_r;
  logic [dq_pkg::DQ_CW-1:0] pend_count_r;

  logic                     out_valid_r;
  logic [1:0]               out_status_r;
  logic [dq_pkg::DQ_DW-1:0] out_data_r;
  logic [dq_pkg::DQ_CW-1:0] out_count_r;

  // Handshake: read stage drains into the output register when it is free
  assign pend_move = pend_r && (!out_valid_r || out_ready);
  assign in_ready  = !pend_r || pend_move;
  assign accept    = in_valid && in_ready;

  dq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .cmd    (in_cmd),
    .op     (op)
  );

  // RAM read data holds while the read stage is stalled (no new read issued)
  dq_ram #(
    .WIDTH (dq_pkg::DQ_DW),
    .DEPTH (dq_pkg::DQ_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && op.wr_en),
    .waddr (op.wr_addr),
    .wdata (in_push_value),
    .re    (accept && op.rd_en),
    .raddr (op.rd_addr),
    .rdata (ram_rdata)
  );

  // Read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (accept) begin
      pend_r <= 1'b1;
    end else if (pend_move) begin
      pend_r <= 1'b0;
    end
  end

  // Read stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_rd_r     <= op.rd_en;
      pend_status_r <= op.status;
      pend_count_r  <= op.count;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pend_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload; data is zero unless the RAM was read
  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_status_r <= pend_status_r;
      out_data_r   <= pend_rd_r ? ram_rdata : '0;
      out_count_r  <= pend_count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_read_data     = out_data_r;
  assign out_element_count = out_count_r;

  `DQ_ASSERT_NOW(a_err_no_data, clk, rst_n,
                 out_valid_r && out_status_r != dq_pkg::ST_OK, out_data_r == '0)
  `DQ_ASSERT_NOW(a_drain_free, clk, rst_n, pend_r && !out_valid_r, in_ready)
  `DQ_ASSERT_NXT(a_stall_holds, clk, rst_n, pend_r && pend_rd_r && !pend_move,
                 pend_r && $stable(ram_rdata))

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: push, pop, peek and clear at both
// ends, compared against a ring-buffer predictor kept in the bench.
// Depends on dq_pkg for sizes and command/status codes.
module tb;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 48;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] value;
  } dq_cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [31:0]              data;
    logic [dq_pkg::DQ_CW-1:0] count;
  } dq_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_cmd = dq_pkg::CMD_PUSH_FRONT;
  logic signed [dq_pkg::DQ_DW-1:0] in_push_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic signed [dq_pkg::DQ_DW-1:0] out_read_data;
  logic [dq_pkg::DQ_CW-1:0] out_element_count;

  // Stimulus and expected results
  dq_cmd_t    pending_cmds[$];
  dq_result_t expected_results[$];
  int total_items = 0;
  int items_sent = 0;
  int drain_points[2];
  int mismatch_count = 0;
  int hold_left = 0;
  int holds_done = 0;
  bit slot_free;
  dq_result_t want;

  // Predictor state: ring of words, both free-slot pointers and fill level
  logic [31:0] ring_words[dq_pkg::DQ_DEPTH];
  int front_slot = 0;
  int back_slot = dq_pkg::DQ_DEPTH - 1;
  int held = 0;

  double_ended_queue DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_push_value(in_push_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_read_data(out_read_data),
    .out_element_count(out_element_count)
  );

  always #2 clk = ~clk;

  function automatic int ring_next(input int p);
    return (p == dq_pkg::DQ_DEPTH - 1) ? 0 : p + 1;
  endfunction

  function automatic int ring_prev(input int p);
    return (p == 0) ? dq_pkg::DQ_DEPTH - 1 : p - 1;
  endfunction

  // Apply one command to the predicted deque and return its result
  function automatic dq_result_t deque_apply(input logic [2:0] cmd, input logic [31:0] value);
    dq_result_t r;
    bit is_push;
    bit is_read;
    r.status = dq_pkg::ST_OK;
    r.data = '0;
    is_push = (cmd == dq_pkg::CMD_PUSH_FRONT) || (cmd == dq_pkg::CMD_PUSH_AT_BACK);
    is_read = (cmd >= dq_pkg::CMD_POP_AT_FRONT) && (cmd <= dq_pkg::CMD_PEEK_BACK);
    if (is_push && held >= dq_pkg::DQ_DEPTH) begin
      r.status = dq_pkg::ST_FULL;
    end else if (is_read && held == 0) begin
      r.status = dq_pkg::ST_EMPTY;
    end else begin
      case (cmd)
        dq_pkg::CMD_PUSH_FRONT: begin
          ring_words[front_slot] = value;
          front_slot = ring_next(front_slot);
          held++;
        end
        dq_pkg::CMD_PUSH_AT_BACK: begin
          ring_words[back_slot] = value;
          back_slot = ring_prev(back_slot);
          held++;
        end
        dq_pkg::CMD_POP_AT_FRONT: begin
          front_slot = ring_prev(front_slot);
          r.data = ring_words[front_slot];
          held--;
        end
        dq_pkg::CMD_POP_BACK: begin
          back_slot = ring_next(back_slot);
          r.data = ring_words[back_slot];
          held--;
        end
        dq_pkg::CMD_PEEK_FRONT: r.data = ring_words[ring_prev(front_slot)];
        dq_pkg::CMD_PEEK_BACK:  r.data = ring_words[ring_next(back_slot)];
        dq_pkg::CMD_CLEAR: begin
          front_slot = 0;
          back_slot = dq_pkg::DQ_DEPTH - 1;
          held = 0;
        end
        default: ;
      endcase
    end
    r.count = held[dq_pkg::DQ_CW-1:0];
    return r;
  endfunction

  function automatic void add_cmd(input logic [2:0] cmd, input logic [31:0] value);
    dq_cmd_t c;
    c.cmd = cmd;
    c.value = value;
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // Mostly full-range random words, with the extremes mixed in
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] rand_mixed_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return dq_pkg::CMD_PUSH_FRONT;
    if (r < 44) return dq_pkg::CMD_PUSH_AT_BACK;
    if (r < 56) return dq_pkg::CMD_POP_AT_FRONT;
    if (r < 68) return dq_pkg::CMD_POP_BACK;
    if (r < 78) return dq_pkg::CMD_PEEK_FRONT;
    if (r < 88) return dq_pkg::CMD_PEEK_BACK;
    if (r < 94) return dq_pkg::CMD_CLEAR;
    return CMD_UNUSED;
  endfunction

  // Idle rates by run phase: sender-light, then receiver-light, then none
  function automatic int sender_idle_pct();
    int phase;
    phase = (total_items == 0) ? 0 : (items_sent * 3) / total_items;
    return (phase == 0) ? 14 : (phase == 1) ? 60 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    int phase;
    phase = (total_items == 0) ? 0 : (items_sent * 3) / total_items;
    return (phase == 0) ? 60 : (phase == 1) ? 14 : 0;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatch_count < 10) $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Driver: record each transfer in the predictor, then offer the next command
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      slot_free = !in_valid || in_ready;
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(), deque_apply(in_cmd, in_push_value));
        items_sent++;
      end
      if (slot_free) begin
        if (pending_cmds.size() > 0
            && !((items_sent == drain_points[0] || items_sent == drain_points[1])
                 && expected_results.size() > 0)
            && $urandom_range(0, 99) >= sender_idle_pct()) begin
          in_valid <= 1'b1;
          in_cmd <= pending_cmds[0].cmd;
          in_push_value <= pending_cmds[0].value;
          pending_cmds.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result status=%0d data=%0d count=%0d",
                                  out_status, out_read_data, out_element_count));
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_status !== want.status || out_read_data !== want.data
              || out_element_count !== want.count) begin
            flag_mismatch($sformatf(
              "expected status=%0d data=%0d count=%0d, got status=%0d data=%0d count=%0d",
              want.status, $signed(want.data), want.count,
              out_status, out_read_data, out_element_count));
          end
        end
      end
      // Hold off for a long stretch twice so the block backs up its input
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (holds_done < 2
                   && items_sent >= ((holds_done == 0) ? 120 : total_items - 150)) begin
        out_ready <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
        holds_done++;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
    end
  end

  initial begin
    // Directed: empty errors, extremes at both ends, wrap across slot zero, clear
    add_cmd(dq_pkg::CMD_POP_AT_FRONT, 32'h1234_5678);
    add_cmd(dq_pkg::CMD_POP_BACK, 32'h0);
    add_cmd(dq_pkg::CMD_PEEK_FRONT, 32'h0);
    add_cmd(dq_pkg::CMD_PEEK_BACK, 32'h0);
    add_cmd(CMD_UNUSED, 32'hDEAD_BEEF);
    add_cmd(dq_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    add_cmd(dq_pkg::CMD_PUSH_AT_BACK, 32'h8000_0000);
    add_cmd(dq_pkg::CMD_PEEK_FRONT, 32'h0);
    add_cmd(dq_pkg::CMD_PEEK_BACK, 32'h0);
    add_cmd(dq_pkg::CMD_PUSH_FRONT, 32'h0000_0000);
    add_cmd(dq_pkg::CMD_PUSH_AT_BACK, 32'hFFFF_FFFF);
    add_cmd(dq_pkg::CMD_PUSH_FRONT, 32'h5555_5555);
    add_cmd(dq_pkg::CMD_PUSH_AT_BACK, 32'hAAAA_AAAA);
    add_cmd(CMD_UNUSED, 32'hFFFF_FFFF);
    add_cmd(dq_pkg::CMD_POP_AT_FRONT, 32'h0);
    add_cmd(dq_pkg::CMD_POP_BACK, 32'h0);
    add_cmd(dq_pkg::CMD_POP_BACK, 32'h0);
    add_cmd(dq_pkg::CMD_POP_BACK, 32'h0);
    add_cmd(dq_pkg::CMD_POP_BACK, 32'h0);
    add_cmd(dq_pkg::CMD_POP_BACK, 32'h0);
    add_cmd(dq_pkg::CMD_POP_AT_FRONT, 32'h0);
    add_cmd(dq_pkg::CMD_PUSH_AT_BACK, 32'h0000_0001);
    add_cmd(dq_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
    add_cmd(dq_pkg::CMD_CLEAR, 32'h0);
    add_cmd(dq_pkg::CMD_PEEK_BACK, 32'h0);
    drain_points[0] = pending_cmds.size();

    // Random mix at shallow depth
    repeat (250) add_cmd(rand_mixed_cmd(), rand_word());

    // Start empty, then fill deep at both ends, with peeks sprinkled in
    add_cmd(dq_pkg::CMD_CLEAR, rand_word());
    repeat (180) begin
      add_cmd($urandom_range(0, 1) ? dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_AT_BACK,
              rand_word());
      if ($urandom_range(0, 15) == 0)
        add_cmd($urandom_range(0, 1) ? dq_pkg::CMD_PEEK_FRONT : dq_pkg::CMD_PEEK_BACK,
                rand_word());
    end
    drain_points[1] = pending_cmds.size();

    // Drain past empty from both ends
    repeat (240) begin
      add_cmd($urandom_range(0, 1) ? dq_pkg::CMD_POP_AT_FRONT : dq_pkg::CMD_POP_BACK,
              rand_word());
      if ($urandom_range(0, 15) == 0)
        add_cmd($urandom_range(0, 1) ? dq_pkg::CMD_PEEK_FRONT : dq_pkg::CMD_PEEK_BACK,
                rand_word());
    end

    repeat (200) add_cmd(rand_mixed_cmd(), rand_word());
    total_items = pending_cmds.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (items_sent < total_items || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS double_ended_queue");
    end else begin
      $display("FAIL double_ended_queue");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("FAIL double_ended_queue");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/dq_pkg.sv
src/dq_ram.sv
src/dq_ctrl.sv
src/double_ended_queue.sv
test/tb.sv
